### sv/b2d_pkg.sv
`timescale 1ns / 1ps

package b2d_pkg;

    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int DIGIT_COUNT_W  = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int MAX_DIGITS_DEF = 10;

    // The binary value enters the BCD shift register four bits a cycle.
    localparam int BITS_PER_STEP  = 4;
    localparam int CONV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W         = $clog2(CONV_STEPS);

    localparam logic [CHAR_W-1:0] ASCII_BASE = 8'd48;
    localparam logic [CHAR_W-1:0] FILL_SPACE = 8'd32;

    localparam logic                     ASCII_RESET = 1'b1;
    localparam logic                     FILL_RESET  = 1'b0;
    localparam logic [DIGIT_COUNT_W-1:0] COUNT_RESET = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ASCII_DIGITS = 2'd0,
        REG_ZERO_FILL    = 2'd1,
        REG_DIGIT_COUNT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic spill;
    } conv_status_t;

endpackage

### sv/b2d_if.sv
`timescale 1ns / 1ps

interface b2d_in_if
    import b2d_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface b2d_out_if
    import b2d_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              overflow;

    modport source (output valid, output character, output last, output overflow, input ready);
    modport sink (input valid, input character, input last, input overflow, output ready);
endinterface

### sv/b2d_conv.sv
`timescale 1ns / 1ps

module b2d_conv
    import b2d_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [VALUE_W-1:0]            value,
    output logic [DIGIT_W*MAX_DIGITS-1:0] bcd,
    output conv_status_t                  status
);

    localparam int BCD_W = DIGIT_W * MAX_DIGITS;

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic               spill_reg;
    logic               spill_next;
    logic [STEP_W-1:0]  cnt_reg;
    logic [STEP_W-1:0]  cnt_next;
    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic [BCD_W-1:0]   acc;
    logic               acc_spill;

    // Shift-and-add-3 over the BCD register, one input bit per inner pass.
    // A bit leaving the top digit means the value needs more digits than
    // the register holds; the low digits still hold the value modulo the
    // matching power of ten.
    always_comb
    begin
        acc       = bcd_reg;
        acc_spill = spill_reg;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (acc[d*DIGIT_W +: DIGIT_W] >= 4'd5)
                begin
                    acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            acc_spill = acc_spill | acc[BCD_W-1];
            if (BCD_W > 1)
            begin
                acc = {acc[BCD_W-2:0], value_reg[VALUE_W-1-b]};
            end
        end
    end

    always_comb
    begin
        value_next = value_reg;
        bcd_next   = bcd_reg;
        spill_next = spill_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            value_next = value;
            bcd_next   = '0;
            spill_next = 1'b0;
            cnt_next   = STEP_W'(CONV_STEPS - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            value_next = {value_reg[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
            bcd_next   = acc;
            spill_next = acc_spill;
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        bcd_reg   <= bcd_next;
        spill_reg <= spill_next;
    end

    assign bcd          = bcd_reg;
    assign status.busy  = busy_reg;
    assign status.done  = done_reg;
    assign status.spill = spill_reg;

endmodule

### sv/binary_to_decimal_chars.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                       Handshake
// number    sink       value[31:0]                   valid / ready
// chars     source     character[7:0], last, overflow valid / ready
// cfg       write      cfg_index[1:0], cfg_data[3:0] cfg_we
//
// A value is accepted only when the block is idle. It then passes through the BCD
// shift-and-add-3 unit (four bits a cycle), a state that sees the unit finish,
// a state for the overflow check and an emit state that sends one digit per
// cycle while the output is not stalled; a new value is taken only after the
// last digit of the previous one has been emitted.
// Reset clears the registers to ASCII digits, space fill and five digits.
// A stalled output holds the emitter; the digit in the output register waits.

module binary_to_decimal_chars
    import b2d_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    b2d_in_if.sink                number,
    b2d_out_if.source             chars,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BCD_W = DIGIT_W * MAX_DIGITS;
    localparam int DIG_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic                     ascii_reg;
    logic                     fill_reg;
    logic [DIGIT_COUNT_W-1:0] count_reg;

    state_t            state_reg;
    state_t            state_next;
    logic [DIG_W-1:0]  pos_reg;
    logic [DIG_W-1:0]  pos_next;
    logic              seen_reg;
    logic              seen_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              last_reg;
    logic              last_next;
    logic              out_ovf_reg;
    logic              out_ovf_next;

    logic               accept;
    logic               out_free;
    logic [DIG_W-1:0]   first_pos;
    logic [BCD_W-1:0]   bcd;
    conv_status_t       conv_status;
    logic [DIGIT_W-1:0] cur_digit;
    logic               high_nonzero;
    logic [CHAR_W-1:0]  offset;
    logic [CHAR_W-1:0]  fill_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascii_reg <= ASCII_RESET;
            fill_reg  <= FILL_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ASCII_DIGITS: ascii_reg <= cfg_data[0];
                REG_ZERO_FILL:    fill_reg  <= cfg_data[0];
                REG_DIGIT_COUNT:  count_reg <= cfg_data[DIGIT_COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Index of the most significant emitted position, from the clamped count.
    always_comb
    begin
        priority if (count_reg == '0)
        begin
            first_pos = '0;
        end
        else if (int'(count_reg) > MAX_DIGITS)
        begin
            first_pos = DIG_W'(MAX_DIGITS - 1);
        end
        else
        begin
            first_pos = DIG_W'(count_reg - 1'b1);
        end
    end

    assign accept   = number.valid && number.ready;
    assign out_free = !out_valid_reg || chars.ready;

    b2d_conv #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .value  (number.value),
        .bcd    (bcd),
        .status (conv_status)
    );

    // Any nonzero digit above the emitted positions means overflow.
    always_comb
    begin
        high_nonzero = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (DIG_W'(i) > pos_reg && bcd[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                high_nonzero = 1'b1;
            end
        end
    end

    assign cur_digit = bcd[{pos_reg, 2'b00} +: DIGIT_W];
    assign offset    = ascii_reg ? ASCII_BASE : '0;
    assign fill_char = ascii_reg ? (fill_reg ? ASCII_BASE : FILL_SPACE) : '0;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && chars.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next   = first_pos;
                    seen_next  = 1'b0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_status.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                ovf_next   = conv_status.spill | high_nonzero;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = (pos_reg == '0);
                    out_ovf_next   = ovf_reg;
                    // The units digit always prints, even when zero.
                    if (cur_digit != '0 || seen_reg || pos_reg == '0)
                    begin
                        char_next = {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit} + offset;
                    end
                    else
                    begin
                        char_next = fill_char;
                    end
                    seen_next = seen_reg | (cur_digit != '0);
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg    <= char_next;
        last_reg    <= last_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign number.ready    = (state_reg == ST_IDLE);
    assign chars.valid     = out_valid_reg;
    assign chars.character = char_reg;
    assign chars.last      = last_reg;
    assign chars.overflow  = out_ovf_reg;

endmodule

### sv/b2d_checker.sv
`timescale 1ns / 1ps

module b2d_checker
    import b2d_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] out_character,
    input logic              out_last,
    input logic              out_overflow
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_character)
            && $stable(out_last) && $stable(out_overflow))
        else $error("stalled result changed");

    // Once a request is taken, the block is busy converting it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while conversion busy");

    // While a run is partly emitted, no new request may enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("ready raised in the middle of a run");

endmodule

bind binary_to_decimal_chars b2d_checker u_b2d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (number.valid),
    .in_ready      (number.ready),
    .out_valid     (chars.valid),
    .out_ready     (chars.ready),
    .out_character (chars.character),
    .out_last      (chars.last),
    .out_overflow  (chars.overflow)
);
